/* hw/rtl/rmq_pkg.sv */
// ============================================================================
// rmq_pkg: shared types and constants for the matrix-to-quaternion block
// Holds the element widths and the branch codes that the front end hands to
// the back end through the decoupling queue.
// ============================================================================
`default_nettype none

package rmq_pkg;

    // Width of one matrix entry and of one quaternion component.
    localparam int ELEM_W = 16;
    // Width of a signed sum or difference of two entries.
    localparam int DIFF_W = 18;
    // Width of the magnitude of such a sum or difference.
    localparam int MAG_W  = 17;
    // Quotient bits developed by the divider; 2^16 is the clamp value.
    localparam int QUOT_W = 17;

    typedef logic [1:0] sel_t;

    // Which component takes the half-root value.
    localparam sel_t SEL_W = 2'd0;
    localparam sel_t SEL_X = 2'd1;
    localparam sel_t SEL_Y = 2'd2;
    localparam sel_t SEL_Z = 2'd3;

    localparam logic [ELEM_W-1:0] SAT_POS = 16'h7fff;
    localparam logic [ELEM_W-1:0] SAT_NEG = 16'h8000;
    localparam logic [QUOT_W-1:0] QUOT_CLAMP = 17'h10000;

endpackage

`default_nettype wire

/* hw/rtl/rmq_front.sv */
// ============================================================================
// rmq_front: branch selection and operand preparation
// Picks the branch from the trace and the diagonal, forms the radicand and
// the three off-diagonal numerators in the order the back end expects.
// ============================================================================
`default_nettype none

module rmq_front #(
    parameter int FRAC_BITS = 14
) (
    input  logic signed [rmq_pkg::ELEM_W-1:0] m00,
    input  logic signed [rmq_pkg::ELEM_W-1:0] m01,
    input  logic signed [rmq_pkg::ELEM_W-1:0] m02,
    input  logic signed [rmq_pkg::ELEM_W-1:0] m10,
    input  logic signed [rmq_pkg::ELEM_W-1:0] m11,
    input  logic signed [rmq_pkg::ELEM_W-1:0] m12,
    input  logic signed [rmq_pkg::ELEM_W-1:0] m20,
    input  logic signed [rmq_pkg::ELEM_W-1:0] m21,
    input  logic signed [rmq_pkg::ELEM_W-1:0] m22,
    output rmq_pkg::sel_t                     sel,
    output logic [((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1:0] rad,
    output logic [2:0][rmq_pkg::DIFF_W-1:0]   dnum
);

    localparam int RADW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int RSW  = RADW + 1;
    localparam int DW   = rmq_pkg::DIFF_W;

    logic signed [DW-1:0]  trace;
    logic signed [RSW-1:0] one_v;
    logic signed [RSW-1:0] e00;
    logic signed [RSW-1:0] e11;
    logic signed [RSW-1:0] e22;
    logic signed [RSW-1:0] rad_s;
    logic signed [DW-1:0]  s01;
    logic signed [DW-1:0]  s02;
    logic signed [DW-1:0]  s12;
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
    logic signed [DW-1:0]  dz;

    always_comb
    begin
        trace = DW'(m00) + DW'(m11) + DW'(m22);
        one_v = {{(RSW-1){1'b0}}, 1'b1} << FRAC_BITS;
        e00   = RSW'(m00);
        e11   = RSW'(m11);
        e22   = RSW'(m22);
        s01   = DW'(m01) + DW'(m10);
        s02   = DW'(m02) + DW'(m20);
        s12   = DW'(m12) + DW'(m21);
        dx    = DW'(m21) - DW'(m12);
        dy    = DW'(m02) - DW'(m20);
        dz    = DW'(m10) - DW'(m01);

        // Numerators are listed in x, y, z, w order with the half slot left out.
        priority if (!trace[DW-1] && (trace != '0))
        begin
            sel   = rmq_pkg::SEL_W;
            rad_s = one_v + RSW'(trace);
            dnum  = {dz, dy, dx};
        end
        else if ((m00 > m11) && (m00 > m22))
        begin
            sel   = rmq_pkg::SEL_X;
            rad_s = one_v + e00 - e11 - e22;
            dnum  = {dx, s02, s01};
        end
        else if (m11 > m22)
        begin
            sel   = rmq_pkg::SEL_Y;
            rad_s = one_v + e11 - e00 - e22;
            dnum  = {dy, s12, s01};
        end
        else
        begin
            sel   = rmq_pkg::SEL_Z;
            rad_s = one_v + e22 - e00 - e11;
            dnum  = {dz, s12, s02};
        end

        // A non-positive radicand only comes from a non-rotation; treat as zero.
        rad = (!rad_s[RSW-1] && (rad_s != '0)) ? rad_s[RADW-1:0] : '0;
    end

endmodule

`default_nettype wire

/* hw/rtl/rmq_queue.sv */
// ============================================================================
// rmq_queue: two-entry request queue
// Decouples the front end from the back-end pipeline.
// ============================================================================
`default_nettype none

module rmq_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [0:1];
    logic             wptr_reg;
    logic             wptr_next;
    logic             rptr_reg;
    logic             rptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rdata   = mem_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wptr_next  = do_push ? !wptr_reg : wptr_reg;
        rptr_next  = do_pop ? !rptr_reg : rptr_reg;
        count_next = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rmq_back.sv */
// ============================================================================
// rmq_back: square root and division pipeline
// One root bit per stage, then one quotient bit per stage for three lanes,
// then rounding, saturation and placement into the output register.
// ============================================================================
`default_nettype none

module rmq_back #(
    parameter int FRAC_BITS = 14
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  rmq_pkg::sel_t                      in_sel,
    input  logic [((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1:0] in_rad,
    input  logic [2:0][rmq_pkg::DIFF_W-1:0]    in_dnum,
    output logic                               out_valid,
    input  logic                               out_pop,
    output logic signed [rmq_pkg::ELEM_W-1:0]  out_x,
    output logic signed [rmq_pkg::ELEM_W-1:0]  out_y,
    output logic signed [rmq_pkg::ELEM_W-1:0]  out_z,
    output logic signed [rmq_pkg::ELEM_W-1:0]  out_w,
    output logic                               out_degen
);

    localparam int RADW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int RB   = (RADW + FRAC_BITS + 1) / 2;
    localparam int NB   = 2 * RB;
    localparam int CW   = ((FRAC_BITS > RB) ? FRAC_BITS : RB) + 19;
    localparam int QW   = rmq_pkg::QUOT_W;
    localparam int DW   = rmq_pkg::DIFF_W;
    localparam int EW   = rmq_pkg::ELEM_W;

    logic adv;

    // Square-root stages.
    logic                sq_v_reg   [0:RB];
    logic [NB-1:0]       sq_n_reg   [0:RB];
    logic [NB-1:0]       sq_res_reg [0:RB];
    rmq_pkg::sel_t       sq_sel_reg [0:RB];
    logic [2:0][DW-1:0]  sq_d_reg   [0:RB];

    // Division stages.
    logic                dv_v_reg   [0:QW];
    logic [RB-1:0]       dv_r_reg   [0:QW];
    rmq_pkg::sel_t       dv_sel_reg [0:QW];
    logic [2:0]          dv_neg_reg [0:QW];
    logic [2:0]          dv_ovf_reg [0:QW];
    logic [2:0][QW-1:0]  dv_q_reg   [0:QW];
    logic [CW-1:0]       dv_rem_reg [0:QW][0:2];

    logic                out_v_reg;
    logic [EW-1:0]       x_reg;
    logic [EW-1:0]       y_reg;
    logic [EW-1:0]       z_reg;
    logic [EW-1:0]       w_reg;
    logic                degen_reg;

    assign adv       = !out_v_reg || out_pop;
    assign in_ready  = adv;
    assign out_valid = out_v_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_w     = w_reg;
    assign out_degen = degen_reg;

    function automatic logic [EW-1:0] sat_quot(input logic neg, input logic ovf,
                                               input logic [QW-1:0] q);
        logic [QW-1:0] m;
        logic [EW-1:0] res;
        begin
            m = (ovf || (q > rmq_pkg::QUOT_CLAMP)) ? rmq_pkg::QUOT_CLAMP : q;
            if (!neg)
            begin
                res = (m > QW'(32767)) ? rmq_pkg::SAT_POS : m[EW-1:0];
            end
            else
            begin
                res = (m > QW'(32768)) ? rmq_pkg::SAT_NEG : EW'(-m);
            end
            return res;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= RB; i++)
            begin
                sq_v_reg[i] <= 1'b0;
            end
            for (int i = 0; i <= QW; i++)
            begin
                dv_v_reg[i] <= 1'b0;
            end
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            sq_v_reg[0] <= in_valid;
            for (int i = 1; i <= RB; i++)
            begin
                sq_v_reg[i] <= sq_v_reg[i-1];
            end
            dv_v_reg[0] <= sq_v_reg[RB];
            for (int i = 1; i <= QW; i++)
            begin
                dv_v_reg[i] <= dv_v_reg[i-1];
            end
            out_v_reg <= dv_v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_n_reg[0]   <= NB'(in_rad) << FRAC_BITS;
            sq_res_reg[0] <= '0;
            sq_sel_reg[0] <= in_sel;
            sq_d_reg[0]   <= in_dnum;
        end
    end

    for (genvar s = 1; s <= RB; s++)
    begin : g_sq
        logic [NB-1:0] bitv;
        logic [NB-1:0] trial;
        logic          fit;
        logic [NB-1:0] n_next;
        logic [NB-1:0] res_next;

        always_comb
        begin
            bitv     = NB'(1) << (2 * (RB - s));
            trial    = sq_res_reg[s-1] + bitv;
            fit      = (sq_n_reg[s-1] >= trial);
            n_next   = fit ? (sq_n_reg[s-1] - trial) : sq_n_reg[s-1];
            res_next = fit ? ((sq_res_reg[s-1] >> 1) + bitv) : (sq_res_reg[s-1] >> 1);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_n_reg[s]   <= n_next;
                sq_res_reg[s] <= res_next;
                sq_sel_reg[s] <= sq_sel_reg[s-1];
                sq_d_reg[s]   <= sq_d_reg[s-1];
            end
        end
    end

    // Divider setup: numerator |d| * 2^F + r, divisor 2r, early overflow check.
    for (genvar l = 0; l < 3; l++)
    begin : g_dsetup
        logic signed [DW-1:0] dd;
        logic [DW-1:0]        magv;
        logic [CW-1:0]        num;
        logic [CW-1:0]        den;

        always_comb
        begin
            dd   = $signed(sq_d_reg[RB][l]);
            magv = dd[DW-1] ? DW'(-dd) : dd;
            num  = (CW'(magv[rmq_pkg::MAG_W-1:0]) << FRAC_BITS)
                   + CW'(sq_res_reg[RB][RB-1:0]);
            den  = CW'(sq_res_reg[RB][RB-1:0]) << 1;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_neg_reg[0][l] <= dd[DW-1];
                dv_ovf_reg[0][l] <= (num >= (den << QW));
                dv_q_reg[0][l]   <= '0;
                dv_rem_reg[0][l] <= num;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_r_reg[0]   <= sq_res_reg[RB][RB-1:0];
            dv_sel_reg[0] <= sq_sel_reg[RB];
        end
    end

    for (genvar j = 1; j <= QW; j++)
    begin : g_dv
        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            logic [CW-1:0] sub;
            logic          fit;

            always_comb
            begin
                sub = (CW'(dv_r_reg[j-1]) << 1) << (QW - j);
                fit = (dv_rem_reg[j-1][l] >= sub);
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_rem_reg[j][l] <= fit ? (dv_rem_reg[j-1][l] - sub)
                                            : dv_rem_reg[j-1][l];
                    dv_q_reg[j][l]   <= dv_q_reg[j-1][l] | (fit ? (QW'(1) << (QW - j)) : '0);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_r_reg[j]   <= dv_r_reg[j-1];
                dv_sel_reg[j] <= dv_sel_reg[j-1];
                dv_neg_reg[j] <= dv_neg_reg[j-1];
                dv_ovf_reg[j] <= dv_ovf_reg[j-1];
            end
        end
    end

    // Rounding, saturation and placement.
    logic [RB:0]   hh;
    logic [EW-1:0] hv;
    logic [EW-1:0] qv0;
    logic [EW-1:0] qv1;
    logic [EW-1:0] qv2;
    logic          degen;
    logic [EW-1:0] x_next;
    logic [EW-1:0] y_next;
    logic [EW-1:0] z_next;
    logic [EW-1:0] w_next;

    always_comb
    begin
        hh    = ({1'b0, dv_r_reg[QW]} + (RB+1)'(1)) >> 1;
        hv    = (hh > (RB+1)'(32767)) ? rmq_pkg::SAT_POS : EW'(hh);
        qv0   = sat_quot(dv_neg_reg[QW][0], dv_ovf_reg[QW][0], dv_q_reg[QW][0]);
        qv1   = sat_quot(dv_neg_reg[QW][1], dv_ovf_reg[QW][1], dv_q_reg[QW][1]);
        qv2   = sat_quot(dv_neg_reg[QW][2], dv_ovf_reg[QW][2], dv_q_reg[QW][2]);
        degen = (dv_r_reg[QW] == '0);
        unique case (dv_sel_reg[QW])
            rmq_pkg::SEL_W:
            begin
                x_next = qv0; y_next = qv1; z_next = qv2; w_next = hv;
            end
            rmq_pkg::SEL_X:
            begin
                x_next = hv;  y_next = qv0; z_next = qv1; w_next = qv2;
            end
            rmq_pkg::SEL_Y:
            begin
                x_next = qv0; y_next = hv;  z_next = qv1; w_next = qv2;
            end
            default:
            begin
                x_next = qv0; y_next = qv1; z_next = hv;  w_next = qv2;
            end
        endcase
        if (degen)
        begin
            x_next = '0;
            y_next = '0;
            z_next = '0;
            w_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            w_reg     <= w_next;
            degen_reg <= degen;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rotation_matrix_to_quaternion.sv */
// ============================================================================
// rotation_matrix_to_quaternion: 3x3 rotation matrix to unit quaternion
// Streams one matrix per request in and one quaternion per request out.
// ============================================================================
// Usage. Both sides look like a queue. The sender drives the nine entries
// r0c0..r2c2 and raises push; the request is taken at a clock edge where
// full is low. The receiver sees the oldest result on quat_x..quat_w and
// degenerate while empty is low, and takes it by raising pop.
// The square-root pipeline develops one root bit per stage, RB bits in all,
// where RB = (max(FRAC_BITS,17) + FRAC_BITS + 3) / 2, and each of the three
// parallel divider lanes develops one quotient bit per stage before the
// result is rounded, saturated and placed into the output register.
// Throughput is one request per cycle: a two-entry queue sits between the
// branch-select front end and the arithmetic pipeline, and the pipeline
// advances whenever its output register is free or being popped.
// When the receiver stalls, the pipeline freezes in place, the queue fills
// and full rises; no result is lost. Reset empties the queue and clears all
// pipeline valid bits, so empty is high and full is low after reset.
// ============================================================================
`default_nettype none

module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r0c0,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r0c1,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r0c2,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r1c0,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r1c1,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r1c2,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r2c0,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r2c1,
    input  logic signed [rmq_pkg::ELEM_W-1:0] r2c2,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [rmq_pkg::ELEM_W-1:0] quat_x,
    output logic signed [rmq_pkg::ELEM_W-1:0] quat_y,
    output logic signed [rmq_pkg::ELEM_W-1:0] quat_z,
    output logic signed [rmq_pkg::ELEM_W-1:0] quat_w,
    output logic                              degenerate
);

    // Radicand width: one plus up to three full-scale entries.
    localparam int RADW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int NUMW = 3 * rmq_pkg::DIFF_W;
    localparam int QDW  = 2 + RADW + NUMW;

    rmq_pkg::sel_t                    f_sel;
    logic [RADW-1:0]                  f_rad;
    logic [2:0][rmq_pkg::DIFF_W-1:0]  f_dnum;
    logic [QDW-1:0]                   q_wdata;
    logic [QDW-1:0]                   q_rdata;
    logic                             q_empty;
    logic                             b_ready;
    logic                             b_valid;

    // The front end classifies each request combinationally as it is pushed.
    rmq_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .m00  (r0c0),
        .m01  (r0c1),
        .m02  (r0c2),
        .m10  (r1c0),
        .m11  (r1c1),
        .m12  (r1c2),
        .m20  (r2c0),
        .m21  (r2c1),
        .m22  (r2c2),
        .sel  (f_sel),
        .rad  (f_rad),
        .dnum (f_dnum)
    );

    assign q_wdata = {f_sel, f_rad, f_dnum};

    rmq_queue #(
        .WIDTH (QDW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (q_wdata),
        .full  (full),
        .pop   (b_ready),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    rmq_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!q_empty),
        .in_ready  (b_ready),
        .in_sel    (q_rdata[QDW-1 -: 2]),
        .in_rad    (q_rdata[NUMW +: RADW]),
        .in_dnum   (q_rdata[NUMW-1:0]),
        .out_valid (b_valid),
        .out_pop   (pop),
        .out_x     (quat_x),
        .out_y     (quat_y),
        .out_z     (quat_z),
        .out_w     (quat_w),
        .out_degen (degenerate)
    );

    assign empty = !b_valid;

endmodule

`default_nettype wire

/* test/tb.sv */
// ============================================================================
// tb: matrix-to-quaternion stream test
// Feeds directed matrices, random rotation matrices, diagonal-tie matrices
// and raw random bit patterns. Each result is checked field by field against
// an in-bench fixed-point predictor, with random idling on both handshakes.
// ============================================================================
`timescale 1ns / 1ps

module tb;

    localparam int FRAC     = 14;
    localparam longint ONE  = longint'(1) << FRAC;
    localparam int SETTLE   = 80;    // covers the pipeline latency with margin

    typedef logic signed [rmq_pkg::ELEM_W-1:0] matrix_t [9];

    typedef struct {
        logic signed [rmq_pkg::ELEM_W-1:0] x;
        logic signed [rmq_pkg::ELEM_W-1:0] y;
        logic signed [rmq_pkg::ELEM_W-1:0] z;
        logic signed [rmq_pkg::ELEM_W-1:0] w;
        logic                              degen;
    } quat_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              push = 1'b0;
    logic                              pop = 1'b0;
    logic                              full;
    logic                              empty;
    logic signed [rmq_pkg::ELEM_W-1:0] entry [9] = '{default: '0};
    logic signed [rmq_pkg::ELEM_W-1:0] quat_x;
    logic signed [rmq_pkg::ELEM_W-1:0] quat_y;
    logic signed [rmq_pkg::ELEM_W-1:0] quat_z;
    logic signed [rmq_pkg::ELEM_W-1:0] quat_w;
    logic                              degenerate;

    // When set, neither the sender nor the receiver idles.
    bit     steady = 1'b0;
    int     errors = 0;
    quat_t  pending_quats[$];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    rotation_matrix_to_quaternion i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .r0c0      (entry[0]),
        .r0c1      (entry[1]),
        .r0c2      (entry[2]),
        .r1c0      (entry[3]),
        .r1c1      (entry[4]),
        .r1c2      (entry[5]),
        .r2c0      (entry[6]),
        .r2c1      (entry[7]),
        .r2c2      (entry[8]),
        .empty     (empty),
        .pop       (pop),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .quat_w    (quat_w),
        .degenerate(degenerate)
    );

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Exact floor square root, one result bit per pass.
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bit_val;
        root = 0;
        bit_val = longint'(1) << 62;
        while (bit_val > n)
            bit_val = bit_val >> 2;
        while (bit_val != 0)
        begin
            if (n >= root + bit_val)
            begin
                n = n - (root + bit_val);
                root = (root >> 1) + bit_val;
            end
            else
                root = root >> 1;
            bit_val = bit_val >> 2;
        end
        return root;
    endfunction

    function automatic logic signed [rmq_pkg::ELEM_W-1:0] sat_elem(longint v);
        if (v > 32767)
            return rmq_pkg::SAT_POS;
        if (v < -32768)
            return rmq_pkg::SAT_NEG;
        return v[rmq_pkg::ELEM_W-1:0];
    endfunction

    // d / (2r) in fixed point, rounded to nearest with ties away from zero.
    function automatic logic signed [rmq_pkg::ELEM_W-1:0] scaled_quotient(longint d,
                                                                 longint unsigned r);
        longint unsigned mag;
        longint unsigned q;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        q = ((mag << FRAC) + r) / (r << 1);
        if (q > 65536)
            q = 65536;
        return sat_elem((d < 0) ? -longint'(q) : longint'(q));
    endfunction

    function automatic logic signed [rmq_pkg::ELEM_W-1:0] half_root(longint unsigned r);
        longint unsigned h;
        h = (r + 1) >> 1;
        if (h > 32767)
            h = 32767;
        return h[rmq_pkg::ELEM_W-1:0];
    endfunction

    function automatic quat_t predict_quat(matrix_t m);
        longint          a [9];
        longint          trace;
        longint          radicand;
        longint unsigned root;
        rmq_pkg::sel_t   sel;
        quat_t           q;
        foreach (a[i])
            a[i] = longint'(m[i]);
        q = '{x: '0, y: '0, z: '0, w: '0, degen: 1'b0};
        trace = a[0] + a[4] + a[8];
        // The diagonal comparisons are strict, so ties fall to the later branch.
        if (trace > 0)
        begin
            sel = rmq_pkg::SEL_W;
            radicand = ONE + trace;
        end
        else if (a[0] > a[4] && a[0] > a[8])
        begin
            sel = rmq_pkg::SEL_X;
            radicand = ONE + a[0] - a[4] - a[8];
        end
        else if (a[4] > a[8])
        begin
            sel = rmq_pkg::SEL_Y;
            radicand = ONE + a[4] - a[0] - a[8];
        end
        else
        begin
            sel = rmq_pkg::SEL_Z;
            radicand = ONE + a[8] - a[0] - a[4];
        end
        root = (radicand > 0) ? int_sqrt(longint'(radicand) << FRAC) : 0;
        if (root == 0)
            q.degen = 1'b1;
        else
        begin
            case (sel)
                rmq_pkg::SEL_W:
                begin
                    q.w = half_root(root);
                    q.x = scaled_quotient(a[7] - a[5], root);
                    q.y = scaled_quotient(a[2] - a[6], root);
                    q.z = scaled_quotient(a[3] - a[1], root);
                end
                rmq_pkg::SEL_X:
                begin
                    q.w = scaled_quotient(a[7] - a[5], root);
                    q.x = half_root(root);
                    q.y = scaled_quotient(a[1] + a[3], root);
                    q.z = scaled_quotient(a[2] + a[6], root);
                end
                rmq_pkg::SEL_Y:
                begin
                    q.w = scaled_quotient(a[2] - a[6], root);
                    q.x = scaled_quotient(a[1] + a[3], root);
                    q.y = half_root(root);
                    q.z = scaled_quotient(a[5] + a[7], root);
                end
                default:
                begin
                    q.w = scaled_quotient(a[3] - a[1], root);
                    q.x = scaled_quotient(a[2] + a[6], root);
                    q.y = scaled_quotient(a[5] + a[7], root);
                    q.z = half_root(root);
                end
            endcase
        end
        return q;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver and result checker
    // ------------------------------------------------------------------------

    // Sends one matrix; the prediction is queued at the edge that takes it.
    task automatic send_matrix(matrix_t m);
        while (!steady && $urandom_range(99) < 29)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        foreach (entry[i])
            entry[i] <= m[i];
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_quats.push_back(predict_quat(m));
    endtask

    // The receiver pops at random unless a steady stretch is running.
    always @(posedge clk)
        pop <= steady || ($urandom_range(99) >= 29);

    task automatic check_field(string name, logic signed [rmq_pkg::ELEM_W-1:0] expected,
                               logic signed [rmq_pkg::ELEM_W-1:0] actual);
        if (actual !== expected)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d",
                     $time, name, expected, actual);
            errors++;
        end
    endtask

    // Every popped result is compared against the oldest prediction.
    always @(posedge clk)
    begin
        quat_t exp_q;
        if (rst_n && pop && !empty)
        begin
            if (pending_quats.size() == 0)
            begin
                $display("%0t ns: result popped with no request outstanding", $time);
                errors++;
            end
            else
            begin
                exp_q = pending_quats.pop_front();
                check_field("quat_x", exp_q.x, quat_x);
                check_field("quat_y", exp_q.y, quat_y);
                check_field("quat_z", exp_q.z, quat_z);
                check_field("quat_w", exp_q.w, quat_w);
                check_field("degenerate", rmq_pkg::ELEM_W'(exp_q.degen),
                            rmq_pkg::ELEM_W'(degenerate));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Matrix builders
    // ------------------------------------------------------------------------

    function automatic logic signed [rmq_pkg::ELEM_W-1:0] to_fixed(real v);
        int n;
        n = $rtoi(v * 16384.0) + int'($urandom_range(6)) - 3;
        if (n > 32767)
            n = 32767;
        if (n < -32768)
            n = -32768;
        return n[rmq_pkg::ELEM_W-1:0];
    endfunction

    function automatic real rand_unit();
        return real'(int'($urandom_range(20000)) - 10000) / 10000.0;
    endfunction

    // Rotation matrix from a random unit quaternion, with a little noise.
    function automatic matrix_t random_rotation();
        real     qw, qx, qy, qz, norm;
        matrix_t m;
        qw = rand_unit();
        qx = rand_unit();
        qy = rand_unit();
        qz = rand_unit();
        norm = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
        if (norm < 0.001)
        begin
            qw = 1.0;
            norm = 1.0;
        end
        qw /= norm;
        qx /= norm;
        qy /= norm;
        qz /= norm;
        m[0] = to_fixed(1.0 - 2.0 * (qy * qy + qz * qz));
        m[1] = to_fixed(2.0 * (qx * qy - qz * qw));
        m[2] = to_fixed(2.0 * (qx * qz + qy * qw));
        m[3] = to_fixed(2.0 * (qx * qy + qz * qw));
        m[4] = to_fixed(1.0 - 2.0 * (qx * qx + qz * qz));
        m[5] = to_fixed(2.0 * (qy * qz - qx * qw));
        m[6] = to_fixed(2.0 * (qx * qz - qy * qw));
        m[7] = to_fixed(2.0 * (qy * qz + qx * qw));
        m[8] = to_fixed(1.0 - 2.0 * (qx * qx + qy * qy));
        return m;
    endfunction

    function automatic matrix_t random_bits();
        matrix_t m;
        foreach (m[i])
            m[i] = rmq_pkg::ELEM_W'($urandom_range(16'hffff));
        return m;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Identity, half turns about each axis, diagonal ties, extreme entries
    // and matrices that are no rotation at all.
    task automatic test_directed();
        matrix_t m;
        m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
        send_matrix(m);
        m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};
        send_matrix(m);
        m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};
        send_matrix(m);
        m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};
        send_matrix(m);
        m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384};
        send_matrix(m);
        m = '{default: '0};
        send_matrix(m);
        m = '{default: 16'sh7fff};
        send_matrix(m);
        m = '{default: 16'sh8000};
        send_matrix(m);
        m = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767};
        send_matrix(m);
        m = '{-5000, 0, 0, 0, -5000, 0, 0, 0, -6000};
        send_matrix(m);
        m = '{-6000, 0, 0, 0, -5000, 0, 0, 0, -5000};
        send_matrix(m);
        m = '{1, -32768, 32767, 32767, 0, -32768, -32768, 32767, -1};
        send_matrix(m);
        m = '{-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768};
        send_matrix(m);
        m = '{32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768, -32768};
        send_matrix(m);
        m = '{-1, 12345, -12345, 0, 0, 32767, 32767, -32768, 1};
        send_matrix(m);
        m = '{-32768, 100, 200, 300, -32768, 400, 500, 600, -32768};
        send_matrix(m);
    endtask

    // Well-formed rotations; the middle part runs with no idling at all.
    task automatic test_rotations(int count);
        for (int i = 0; i < count; i++)
        begin
            steady = (i >= count / 3) && (i < count / 3 + 150);
            send_matrix(random_rotation());
        end
        steady = 1'b0;
    endtask

    // Equal or nearly equal diagonal entries; the trace is non-positive unless the drawn diagonal value is zero.
    task automatic test_diagonal_ties(int count);
        matrix_t m;
        logic signed [rmq_pkg::ELEM_W-1:0] d;
        for (int i = 0; i < count; i++)
        begin
            m = random_bits();
            d = rmq_pkg::ELEM_W'(-int'($urandom_range(32767)));
            m[0] = rmq_pkg::ELEM_W'(int'(d) + int'($urandom_range(1)));
            m[4] = rmq_pkg::ELEM_W'(int'(d) + int'($urandom_range(1)));
            m[8] = rmq_pkg::ELEM_W'(int'(d) + int'($urandom_range(1)));
            send_matrix(m);
        end
    endtask

    task automatic test_random_bits(int count);
        for (int i = 0; i < count; i++)
            send_matrix(random_bits());
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_rotations(1000);
        test_diagonal_ties(120);
        test_random_bits(260);

        push <= 1'b0;
        while (pending_quats.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // Far beyond the slowest correct run.
    initial
    begin
        #4_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule

/* rotation_matrix_to_quaternion.f */
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_front.sv
hw/rtl/rmq_queue.sv
hw/rtl/rmq_back.sv
hw/rtl/rotation_matrix_to_quaternion.sv
test/tb.sv
